### src/gpic_pkg.sv
// Shared types, constants and helper functions of the pin interrupt controller.
package gpic_pkg;

   localparam int MAX_PINS   = 512;
   localparam int MAX_GROUPS = 7;
   localparam int WORDS      = MAX_PINS / 32;
   localparam int PIN_W      = 9;
   localparam int WORD_W     = 4;
   localparam int GRP_W      = 3;
   localparam int ST_DEPTH   = MAX_GROUPS * WORDS;
   localparam int ST_AW      = GRP_W + WORD_W;
   localparam int LSB_W      = 6;

   localparam logic [31:0]      CFG_RESET     = 32'h0007_000E;
   localparam logic [9:0]       NPL_WORD_ADDR = 10'h312;
   localparam logic [GRP_W-1:0] MASKED_GROUP  = 3'd7;
   localparam logic [LSB_W-1:0] LSB_NONE      = 6'd32;
   localparam logic [PIN_W-1:0] PIN_COUNT_RST = 9'd511;
   localparam logic [GRP_W-1:0] GRP_COUNT_RST = 3'd7;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_PIN   = 2'd2;

   localparam logic [2:0] MODE_INPUT   = 3'd0;
   localparam logic [2:0] MODE_OUTPUT  = 3'd1;
   localparam logic [2:0] MODE_HIGH    = 3'd2;
   localparam logic [2:0] MODE_LOW     = 3'd3;
   localparam logic [2:0] MODE_RISE    = 3'd4;
   localparam logic [2:0] MODE_FALL    = 3'd5;
   localparam logic [2:0] MODE_ANY     = 3'd6;

   localparam logic [1:0] FUNC_PLAIN     = 2'd0;
   localparam logic [1:0] FUNC_ALT_FIRST = 2'd1;

   localparam logic CSR_PIN_COUNT = 1'b0;
   localparam logic CSR_GRP_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_CFG   = 4'b0100,
      ST_STAT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic              en;
      logic              event_upd;
      logic [GRP_W-1:0]  group;
      logic [WORD_W-1:0] word;
      logic [31:0]       data;
   } upd_type;

   function automatic logic [LSB_W-1:0] lowest_set(input logic [31:0] d);
      logic [LSB_W-1:0] res;
      res = LSB_NONE;
      for (int i = 31; i >= 0; i--) begin
         if (d[i]) res = LSB_W'(i);
      end
      return res;
   endfunction

endpackage

### src/gpic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gpic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/gpic_irq_tracker.sv
// Per-word lowest-set-bit summary of the status memory and the group interrupt lines.
module gpic_irq_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [gpic_pkg::PIN_W-1:0]     pin_count,
   input  gpic_pkg::upd_type              upd,
   input  logic [gpic_pkg::GRP_W-1:0]     look_group,
   input  logic [gpic_pkg::WORD_W-1:0]    look_word,
   output logic                           look_zero,
   output logic [gpic_pkg::MAX_GROUPS-1:0] irq_lines
);

   logic [gpic_pkg::LSB_W-1:0] lsb_ff [gpic_pkg::MAX_GROUPS][gpic_pkg::WORDS];
   logic [gpic_pkg::MAX_GROUPS-1:0] irq_ff, irq_in;
   logic [gpic_pkg::LSB_W-1:0] new_lsb;
   logic [gpic_pkg::LSB_W-1:0] cur;
   logic any;

   assign new_lsb = gpic_pkg::lowest_set(upd.data);

   always_comb begin
      any = 1'b0;
      for (int i = 0; i < gpic_pkg::WORDS; i++) begin
         cur = (upd.word == gpic_pkg::WORD_W'(i)) ? new_lsb : lsb_ff[upd.group][i];
         if (cur != gpic_pkg::LSB_NONE &&
             {gpic_pkg::WORD_W'(i), cur[4:0]} < pin_count) any = 1'b1;
      end
   end

   always_comb begin
      irq_in = irq_ff;
      if (upd.en) begin
         if (upd.event_upd) irq_in[upd.group] = any;
         else irq_in[upd.group] = irq_ff[upd.group] & any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_ff <= '0;
         for (int g = 0; g < gpic_pkg::MAX_GROUPS; g++) begin
            for (int w = 0; w < gpic_pkg::WORDS; w++) lsb_ff[g][w] <= gpic_pkg::LSB_NONE;
         end
      end else begin
         irq_ff <= irq_in;
         if (upd.en) lsb_ff[upd.group][upd.word] <= new_lsb;
      end
   end

   assign look_zero = (look_group == gpic_pkg::MASKED_GROUP) ? 1'b1 :
                      (lsb_ff[look_group][look_word] == gpic_pkg::LSB_NONE);
   assign irq_lines = irq_in;

endmodule

### src/gpio_pin_interrupt_controller_top.sv
// Top level of the pin interrupt controller: sequencer, memories and result register.
// Each item is accepted in the idle state, where the configuration memory is read; then the
// status memory is read, and the update and the result are registered once the result register is free.
// A new item is accepted only after the result of the last one is registered. After reset a
// clearing pass writes the reset value into every word of the configuration memory; no item is
// accepted during it, while CSR writes of the pin and group counts are taken at any time.
module gpio_pin_interrupt_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [8:0]  req_pin,
   input  logic        req_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_drive_valid,
   output logic [8:0]  rsp_drive_pin,
   output logic        rsp_drive_level,
   output logic [6:0]  rsp_irq_lines,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data
);

   gpic_pkg::state_type state_ff, state_in;
   logic [gpic_pkg::PIN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [gpic_pkg::PIN_W-1:0] pin_count_ff;
   logic [gpic_pkg::GRP_W-1:0] group_count_ff;
   logic [1:0]  kind_ff;
   logic [9:0]  word_ff;
   logic [31:0] data_ff;
   logic [8:0]  pin_ff;
   logic        level_ff;
   logic        zero_ff;
   logic [31:0] npl_ff;
   logic [31:0] input_ff [gpic_pkg::WORDS];
   logic [31:0] prev_ff  [gpic_pkg::WORDS];
   logic        rsp_valid_ff;
   logic [31:0] rsp_read_data_ff;
   logic        rsp_drive_valid_ff;
   logic [8:0]  rsp_drive_pin_ff;
   logic        rsp_drive_level_ff;
   logic [6:0]  rsp_irq_ff;

   logic        accept, finish, out_free;
   logic        cfg_wr_en, cfg_rd_en, st_wr_en, st_rd_en;
   logic [gpic_pkg::PIN_W-1:0] cfg_wr_addr, cfg_rd_addr;
   logic [31:0] cfg_wr_data, cfg_rdata, st_rdata, st_word;
   logic [gpic_pkg::ST_AW-1:0] st_wr_addr, st_rd_addr;
   logic [31:0] st_wr_data;
   logic [gpic_pkg::GRP_W-1:0] look_group;
   logic [gpic_pkg::WORD_W-1:0] look_word;
   logic        look_zero;
   gpic_pkg::upd_type upd;
   logic [6:0]  irq_lines;

   logic [8:0]  p;
   logic        is_cfg, is_st, is_npl, cfg_ok, st_ok;
   logic [gpic_pkg::GRP_W-1:0] sg, eg;
   logic [gpic_pkg::WORD_W-1:0] sw, ew;
   logic [4:0]  eb;
   logic        ev_ok, ev_grp, old, hit;
   logic [31:0] new_in, rd_val, cfg_view;
   logic        dv, dl;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == gpic_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == gpic_pkg::ST_STAT) && out_free;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         gpic_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 9'd1;
            if (clr_cnt_ff == 9'(gpic_pkg::MAX_PINS - 1)) state_in = gpic_pkg::ST_IDLE;
         end
         gpic_pkg::ST_IDLE: if (accept) state_in = gpic_pkg::ST_CFG;
         gpic_pkg::ST_CFG:  state_in = gpic_pkg::ST_STAT;
         gpic_pkg::ST_STAT: if (out_free) state_in = gpic_pkg::ST_IDLE;
         default: state_in = gpic_pkg::ST_CLEAR;
      endcase
   end

   // Decode of the held item.
   assign p      = word_ff[8:0];
   assign is_cfg = !word_ff[9];
   assign sg     = word_ff[6:4];
   assign sw     = word_ff[3:0];
   assign is_st  = word_ff[9] && (word_ff[8:7] == 2'b00) && (sg != gpic_pkg::MASKED_GROUP);
   assign is_npl = (word_ff == gpic_pkg::NPL_WORD_ADDR);
   assign cfg_ok = is_cfg && (p < pin_count_ff);
   assign st_ok  = is_st && (sg < group_count_ff);
   assign eg     = cfg_rdata[18:16];
   assign ew     = pin_ff[8:5];
   assign eb     = pin_ff[4:0];
   assign ev_ok  = pin_ff < pin_count_ff;
   assign ev_grp = ev_ok && (eg != gpic_pkg::MASKED_GROUP) && (eg < group_count_ff);
   assign old    = prev_ff[ew][eb];
   assign st_word = zero_ff ? 32'd0 : st_rdata;

   always_comb begin
      new_in = input_ff[ew];
      new_in[eb] = level_ff;
   end

   always_comb begin
      hit = 1'b0;
      case (cfg_rdata[3:1])
         gpic_pkg::MODE_HIGH: hit = level_ff;
         gpic_pkg::MODE_LOW:  hit = !level_ff;
         gpic_pkg::MODE_RISE: hit = !old && level_ff;
         gpic_pkg::MODE_FALL: hit = old && !level_ff;
         gpic_pkg::MODE_ANY:  hit = old != level_ff;
         default:             hit = 1'b0;
      endcase
   end

   always_comb begin
      cfg_view = cfg_rdata;
      if (cfg_rdata[3:1] == gpic_pkg::MODE_INPUT) cfg_view[0] = input_ff[p[8:5]][p[4:0]];
   end

   always_comb begin
      rd_val = 32'd0;
      dv = 1'b0;
      dl = 1'b0;
      if (kind_ff == gpic_pkg::KIND_READ) begin
         if (cfg_ok) rd_val = cfg_view;
         else if (st_ok) rd_val = st_word;
         else if (is_npl) rd_val = npl_ff;
      end else if (kind_ff == gpic_pkg::KIND_WRITE && cfg_ok) begin
         if (data_ff[6:5] == gpic_pkg::FUNC_PLAIN) begin
            dv = 1'b1;
            dl = (data_ff[3:1] == gpic_pkg::MODE_OUTPUT) ? data_ff[0] : 1'b1;
         end else if (data_ff[6:5] == gpic_pkg::FUNC_ALT_FIRST) begin
            dv = 1'b1;
            dl = 1'b1;
         end
      end
   end

   // Memory ports.
   always_comb begin
      cfg_wr_en   = 1'b0;
      cfg_wr_addr = p;
      cfg_wr_data = data_ff;
      if (state_ff == gpic_pkg::ST_CLEAR) begin
         cfg_wr_en   = 1'b1;
         cfg_wr_addr = clr_cnt_ff;
         cfg_wr_data = gpic_pkg::CFG_RESET;
      end else if (finish && kind_ff == gpic_pkg::KIND_WRITE && cfg_ok) begin
         cfg_wr_en = 1'b1;
      end
   end

   assign cfg_rd_en   = accept;
   assign cfg_rd_addr = (req_kind == gpic_pkg::KIND_PIN) ? req_pin : req_address[10:2];

   always_comb begin
      if (kind_ff == gpic_pkg::KIND_PIN) begin
         look_group = eg;
         look_word  = ew;
         st_rd_en   = (state_ff == gpic_pkg::ST_CFG) && (eg != gpic_pkg::MASKED_GROUP);
      end else begin
         look_group = is_st ? sg : gpic_pkg::MASKED_GROUP;
         look_word  = sw;
         st_rd_en   = (state_ff == gpic_pkg::ST_CFG) && is_st;
      end
   end
   assign st_rd_addr = {look_group, look_word};

   always_comb begin
      upd = '0;
      st_wr_en   = 1'b0;
      st_wr_addr = {sg, sw};
      st_wr_data = data_ff;
      if (finish && kind_ff == gpic_pkg::KIND_WRITE && st_ok) begin
         st_wr_en  = 1'b1;
         upd.en    = 1'b1;
         upd.group = sg;
         upd.word  = sw;
         upd.data  = data_ff;
      end else if (finish && kind_ff == gpic_pkg::KIND_PIN && ev_grp) begin
         st_wr_en   = 1'b1;
         st_wr_addr = {eg, ew};
         st_wr_data = st_word | (32'(hit) << eb);
         upd.en        = 1'b1;
         upd.event_upd = 1'b1;
         upd.group     = eg;
         upd.word      = ew;
         upd.data      = st_wr_data;
      end
   end

   gpic_ram #(.WIDTH(32), .DEPTH(gpic_pkg::MAX_PINS)) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_wr_en),
      .wr_addr (cfg_wr_addr),
      .wr_data (cfg_wr_data),
      .rd_en   (cfg_rd_en),
      .rd_addr (cfg_rd_addr),
      .rd_data (cfg_rdata)
   );

   gpic_ram #(.WIDTH(32), .DEPTH(gpic_pkg::ST_DEPTH)) u_status_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rdata)
   );

   gpic_irq_tracker u_irq_tracker (
      .clock      (clock),
      .reset      (reset),
      .pin_count  (pin_count_ff),
      .upd        (upd),
      .look_group (look_group),
      .look_word  (look_word),
      .look_zero  (look_zero),
      .irq_lines  (irq_lines)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gpic_pkg::ST_CLEAR;
         clr_cnt_ff     <= '0;
         pin_count_ff   <= gpic_pkg::PIN_COUNT_RST;
         group_count_ff <= gpic_pkg::GRP_COUNT_RST;
         npl_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < gpic_pkg::WORDS; i++) begin
            input_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               gpic_pkg::CSR_PIN_COUNT: pin_count_ff   <= csr_write_data;
               gpic_pkg::CSR_GRP_COUNT: group_count_ff <= csr_write_data[2:0];
               default: ;
            endcase
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            if (kind_ff == gpic_pkg::KIND_WRITE && is_npl) npl_ff <= data_ff;
            if (kind_ff == gpic_pkg::KIND_PIN && ev_ok) input_ff[ew] <= new_in;
            if (kind_ff == gpic_pkg::KIND_PIN && ev_grp) prev_ff[ew] <= new_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         word_ff  <= req_address[11:2];
         data_ff  <= req_write_data;
         pin_ff   <= req_pin;
         level_ff <= req_level;
      end
      if (state_ff == gpic_pkg::ST_CFG) zero_ff <= look_zero;
      if (finish) begin
         rsp_read_data_ff   <= rd_val;
         rsp_drive_valid_ff <= dv;
         rsp_drive_pin_ff   <= dv ? p : 9'd0;
         rsp_drive_level_ff <= dl;
         rsp_irq_ff         <= irq_lines;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_drive_valid = rsp_drive_valid_ff;
   assign rsp_drive_pin   = rsp_drive_pin_ff;
   assign rsp_drive_level = rsp_drive_level_ff;
   assign rsp_irq_lines   = rsp_irq_ff;

endmodule

### src/gpic_checker.sv
// Port-level assertions of the pin interrupt controller and their binding.
module gpic_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_drive_valid,
   input logic [8:0]  rsp_drive_pin,
   input logic        rsp_drive_level
);

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("result or ready shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

   a_drive_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_valid |-> rsp_drive_pin == 9'd0 && !rsp_drive_level)
      else $error("drive fields set without a drive");

   a_drive_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_valid |-> rsp_read_data == 32'd0)
      else $error("drive and read data in one item");

endmodule

bind gpio_pin_interrupt_controller_top gpic_checker u_gpic_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_drive_valid (rsp_drive_valid),
   .rsp_drive_pin   (rsp_drive_pin),
   .rsp_drive_level (rsp_drive_level)
);

### tb/gpio_pin_interrupt_controller_top_tb.sv
// Testbench of the pin interrupt controller: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module gpio_pin_interrupt_controller_top_tb;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] address;
      logic [31:0] write_data;
      logic [8:0]  pin;
      logic        level;
   } gpio_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        drive_valid;
      logic [8:0]  drive_pin;
      logic        drive_level;
      logic [6:0]  irq_lines;
   } gpio_result_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [11:0] req_address;
   logic [31:0] req_write_data;
   logic [8:0]  req_pin;
   logic        req_level;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_drive_valid;
   logic [8:0]  rsp_drive_pin;
   logic        rsp_drive_level;
   logic [6:0]  rsp_irq_lines;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [8:0]  csr_write_data;

   gpio_pin_interrupt_controller_top DUT (.*);

   logic [31:0] model_cfg [gpic_pkg::MAX_PINS];
   logic [31:0] model_status [gpic_pkg::MAX_GROUPS * 16];
   logic [31:0] model_inputs [gpic_pkg::WORDS];
   logic [31:0] model_prev [gpic_pkg::WORDS];
   logic [6:0]  model_irq;
   logic [31:0] model_npl;
   logic [8:0]  model_pin_count;
   logic [2:0]  model_grp_count;

   gpio_item_type   pending_items[$];
   gpio_result_type expected_results[$];
   int           items_queued;
   int           req_accepts;
   int           req_seen;
   int           csr_accepts;
   int           mismatches;
   int           cycle_count;
   int           quiet_cycles;
   logic         calm;

   always #4 clock = ~clock;

   assign calm = (cycle_count >= 3000) && (cycle_count < 5000);

   function automatic bit group_has_status(int g);
      int n;
      logic [31:0] m;
      n = model_pin_count;
      for (int w = 0; w < gpic_pkg::WORDS; w++) begin
         if (w * 32 >= n) break;
         m = (n - w * 32 >= 32) ? 32'hFFFF_FFFF : ((32'd1 << (n - w * 32)) - 32'd1);
         if ((model_status[g * 16 + w] & m) != 0) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic gpio_result_type predict_result(gpio_item_type it);
      gpio_result_type r;
      logic [11:0] a;
      logic [31:0] v;
      logic [31:0] bitmask;
      int p, g, w;
      bit hit, old_level;
      r = '0;
      a = {it.address[11:2], 2'b00};
      if (it.kind == gpic_pkg::KIND_WRITE || it.kind == gpic_pkg::KIND_READ) begin
         if (a < 12'h800) begin
            p = a >> 2;
            if (p < model_pin_count) begin
               if (it.kind == gpic_pkg::KIND_WRITE) begin
                  model_cfg[p] = it.write_data;
                  if (it.write_data[6:5] == gpic_pkg::FUNC_PLAIN) begin
                     r.drive_valid = 1'b1;
                     r.drive_level = (it.write_data[3:1] == gpic_pkg::MODE_OUTPUT) ?
                                     it.write_data[0] : 1'b1;
                  end else if (it.write_data[6:5] == gpic_pkg::FUNC_ALT_FIRST) begin
                     r.drive_valid = 1'b1;
                     r.drive_level = 1'b1;
                  end
                  if (r.drive_valid) r.drive_pin = p[8:0];
               end else begin
                  v = model_cfg[p];
                  if (v[3:1] == gpic_pkg::MODE_INPUT) v[0] = model_inputs[p >> 5][p & 31];
                  r.read_data = v;
               end
            end
         end else if (a < 12'h800 + gpic_pkg::MAX_GROUPS * 12'h40) begin
            g = (a - 12'h800) / 12'h40;
            w = (a >> 2) & 15;
            if (g < model_grp_count) begin
               if (it.kind == gpic_pkg::KIND_WRITE) begin
                  model_status[g * 16 + w] = it.write_data;
                  if (!group_has_status(g)) model_irq[g] = 1'b0;
               end else begin
                  r.read_data = model_status[g * 16 + w];
               end
            end
         end else if (a == 12'hC48) begin
            if (it.kind == gpic_pkg::KIND_WRITE) model_npl = it.write_data;
            else r.read_data = model_npl;
         end
      end else if (it.kind == gpic_pkg::KIND_PIN) begin
         if (it.pin < model_pin_count) begin
            w = it.pin >> 5;
            bitmask = 32'd1 << it.pin[4:0];
            v = model_cfg[it.pin];
            g = v[18:16];
            old_level = (model_prev[w] & bitmask) != 0;
            if (it.level) model_inputs[w] |= bitmask;
            else model_inputs[w] &= ~bitmask;
            if (v[18:16] != gpic_pkg::MASKED_GROUP && g < model_grp_count) begin
               case (v[3:1])
                  gpic_pkg::MODE_HIGH: hit = it.level;
                  gpic_pkg::MODE_LOW:  hit = !it.level;
                  gpic_pkg::MODE_RISE: hit = !old_level && it.level;
                  gpic_pkg::MODE_FALL: hit = old_level && !it.level;
                  gpic_pkg::MODE_ANY:  hit = old_level != it.level;
                  default:             hit = 1'b0;
               endcase
               if (hit) model_status[g * 16 + w] |= bitmask;
               model_prev[w] = model_inputs[w];
               model_irq[g] = group_has_status(g);
            end
         end
      end
      r.irq_lines = model_irq;
      return r;
   endfunction

   always @(posedge clock) begin
      gpio_result_type want;
      gpio_result_type got;
      if (reset) begin
         for (int i = 0; i < gpic_pkg::MAX_PINS; i++) model_cfg[i] = gpic_pkg::CFG_RESET;
         for (int i = 0; i < gpic_pkg::MAX_GROUPS * 16; i++) model_status[i] = '0;
         for (int i = 0; i < gpic_pkg::WORDS; i++) begin
            model_inputs[i] = '0;
            model_prev[i] = '0;
         end
         model_irq = '0;
         model_npl = '0;
         model_pin_count = gpic_pkg::PIN_COUNT_RST;
         model_grp_count = gpic_pkg::GRP_COUNT_RST;
         quiet_cycles <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (csr_valid && csr_ready) begin
            if (csr_index == gpic_pkg::CSR_PIN_COUNT) model_pin_count = csr_write_data;
            else model_grp_count = csr_write_data[2:0];
            csr_accepts <= csr_accepts + 1;
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_result({req_kind, req_address, req_write_data,
                                                       req_pin, req_level}));
            req_accepts <= req_accepts + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_read_data, rsp_drive_valid, rsp_drive_pin, rsp_drive_level,
                   rsp_irq_lines};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Result with no item pending: %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %p, actual %p", want, got);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      gpio_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts != req_seen) begin
         req_seen = req_accepts;
         if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
            it = pending_items.pop_front();
            req_kind <= it.kind;
            req_address <= it.address;
            req_write_data <= it.write_data;
            req_pin <= it.pin;
            req_level <= it.level;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= calm || $urandom_range(99) >= 36;
   end

   task automatic add_item(logic [1:0] kind, logic [11:0] address, logic [31:0] data,
                           logic [8:0] pin, logic level);
      gpio_item_type it;
      it.kind = kind;
      it.address = address;
      it.write_data = data;
      it.pin = pin;
      it.level = level;
      pending_items.push_back(it);
      items_queued++;
   endtask

   function automatic logic [31:0] pin_config_word(logic [2:0] mode, logic [1:0] func,
                                                   logic [2:0] grp);
      logic [31:0] d;
      d = $urandom;
      d[3:1] = mode;
      d[6:5] = func;
      d[18:16] = grp;
      return d;
   endfunction

   function automatic logic [8:0] pick_pin();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 9'($urandom_range(47));
      if (r < 90) return 9'($urandom_range(511, 480));
      return 9'($urandom);
   endfunction

   task automatic add_random_item();
      gpio_item_type it;
      int r;
      logic [1:0] func;
      it = 56'({$urandom, $urandom});
      it.kind = gpic_pkg::KIND_WRITE;
      r = $urandom_range(99);
      if (r < 30) begin
         func = ($urandom_range(99) < 70) ? gpic_pkg::FUNC_PLAIN : 2'($urandom);
         it.address = {1'b0, pick_pin(), 2'($urandom)};
         it.write_data = pin_config_word(3'($urandom), func,
                                         ($urandom_range(3) == 0) ? 3'($urandom) :
                                         3'($urandom_range(model_grp_count)));
      end else if (r < 40) begin
         it.kind = gpic_pkg::KIND_READ;
         it.address = {1'b0, pick_pin(), 2'($urandom)};
      end else if (r < 75) begin
         it.kind = gpic_pkg::KIND_PIN;
         it.pin = pick_pin();
      end else if (r < 90) begin
         it.kind = (r < 83) ? gpic_pkg::KIND_WRITE : gpic_pkg::KIND_READ;
         it.address = 12'(12'h800 + 12'h40 * $urandom_range(gpic_pkg::MAX_GROUPS - 1) +
                      4 * (($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1))
                      + $urandom_range(3));
         if ($urandom_range(1) == 0) it.write_data = '0;
      end else if (r < 93) begin
         it.kind = 2'($urandom_range(1));
         it.address = 12'hC48 + 12'($urandom_range(3));
      end else begin
         it.kind = 2'($urandom);
      end
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic write_csr(logic index, logic [8:0] value);
      int n;
      n = csr_accepts;
      @(negedge clock);
      csr_index <= index;
      csr_write_data <= value;
      csr_valid <= 1'b1;
      while (csr_accepts == n) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (req_accepts != items_queued || expected_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      int pin_counts [6] = '{511, 0, 40, 511, 37, 511};
      int grp_counts [6] = '{7, 0, 3, 7, 7, 1};
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_address = '0;
      req_write_data = '0;
      req_pin = '0;
      req_level = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = gpic_pkg::CSR_PIN_COUNT;
      csr_write_data = '0;
      items_queued = 0;
      req_accepts = 0;
      req_seen = 0;
      csr_accepts = 0;
      mismatches = 0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_item(gpic_pkg::KIND_WRITE, 12'h000, 32'h0000_0003, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h004,
               pin_config_word(gpic_pkg::MODE_RISE, gpic_pkg::FUNC_PLAIN, 3'd0), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'hFFF, 32'hFFFF_FFFF, 9'd1, 1'b1);
      add_item(gpic_pkg::KIND_READ, 12'h800, 32'h0, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h800, 32'h0, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h008,
               pin_config_word(gpic_pkg::MODE_FALL, gpic_pkg::FUNC_ALT_FIRST, 3'd1),
               9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd2, 1'b1);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd2, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h00C,
               pin_config_word(gpic_pkg::MODE_HIGH, 2'd2, 3'd2), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd3, 1'b1);
      add_item(gpic_pkg::KIND_WRITE, 12'h010,
               pin_config_word(gpic_pkg::MODE_LOW, 2'd3, 3'd6), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd4, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h014,
               pin_config_word(gpic_pkg::MODE_ANY, gpic_pkg::FUNC_PLAIN, 3'd3), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd5, 1'b1);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd5, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'h018,
               pin_config_word(gpic_pkg::MODE_INPUT, gpic_pkg::FUNC_PLAIN,
                               gpic_pkg::MASKED_GROUP), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd6, 1'b1);
      add_item(gpic_pkg::KIND_READ, 12'h01B, 32'h0, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_WRITE, 12'hC48, 32'hFFFF_FFFF, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_READ, 12'hC4B, 32'h0, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_READ, 12'hFFF, 32'h0, 9'h1FF, 1'b1);
      add_item(2'd3, 12'hFFF, 32'hFFFF_FFFF, 9'h1FF, 1'b1);
      add_item(gpic_pkg::KIND_WRITE, 12'h7FC,
               pin_config_word(gpic_pkg::MODE_ANY, gpic_pkg::FUNC_PLAIN, 3'd4), 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_PIN, 12'h0, 32'h0, 9'd511, 1'b1);
      add_item(gpic_pkg::KIND_WRITE, 12'h980, 32'hFFFF_FFFF, 9'd0, 1'b0);
      add_item(gpic_pkg::KIND_READ, 12'h9C0, 32'h0, 9'd0, 1'b0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(gpic_pkg::CSR_PIN_COUNT, 9'(pin_counts[ph]));
         write_csr(gpic_pkg::CSR_GRP_COUNT, 9'(grp_counts[ph]));
         repeat (3) @(negedge clock);
         for (int i = 0; i < 240; i++) add_random_item();
         drain();
      end

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
src/gpic_pkg.sv
src/gpic_ram.sv
src/gpic_irq_tracker.sv
src/gpio_pin_interrupt_controller_top.sv
src/gpic_checker.sv
tb/gpio_pin_interrupt_controller_top_tb.sv
